// ----- hdl/lidt_pkg.sv -----
// lidt_pkg: shared constants for the link identifier table
// command codes, field widths and the default table depth
// no dependencies
package lidt_pkg;

    // field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int ID_W    = 32;
    localparam int TOTAL_W = 5;

    // default number of table entries
    localparam int DEFAULT_TABLE_DEPTH = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_SRC = 2'd3;

    // source id reported when a destination lookup misses
    localparam logic [ID_W-1:0] MISS_SOURCE = '1;

endpackage

// ----- hdl/link_identifier_table.sv -----
// link_identifier_table: bounded table of (source, destination, service) link ids
// entries, validity and age rank live in one synchronous single-port-per-side memory
// depends on lidt_pkg
//
//   transfer   direction  ports                                   handshake
//   command    in         cmd, source_id, dest_id, service_kind   start & !busy
//   result     out        hit, found_source, dropped, entry_total done, one cycle
//
// A command scans all TABLE_DEPTH entries through the memory read port, one per
// cycle, then decides in ST_DECIDE; the result is strobed in the cycle after.
// A new-key insert with a free slot or a hitting delete then re-ranks all entries
// in a read-modify-write pass through ST_UPDATE and ST_UPDATE_END with busy held
// high, the result strobed as ST_UPDATE begins. After reset a clearing pass holds
// busy high. The result is strobed for one cycle and cannot be held off.
module link_identifier_table #(
    parameter int TABLE_DEPTH = lidt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lidt_pkg::CMD_W-1:0]    cmd,
    input  logic [lidt_pkg::ID_W-1:0]     source_id,
    input  logic [lidt_pkg::ID_W-1:0]     dest_id,
    input  logic [lidt_pkg::ID_W-1:0]     service_kind,
    output logic                          done,
    output logic                          hit,
    output logic [lidt_pkg::ID_W-1:0]     found_source,
    output logic                          dropped,
    output logic [lidt_pkg::TOTAL_W-1:0]  entry_total
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = IW;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IDW = lidt_pkg::ID_W;
    localparam int KW = 3 * IDW;
    localparam int WW = 1 + SW + KW;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_CLEAR      = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_SCAN       = 7'b0000100,
        ST_SCAN_END   = 7'b0001000,
        ST_DECIDE     = 7'b0010000,
        ST_UPDATE     = 7'b0100000,
        ST_UPDATE_END = 7'b1000000
    } state_t;

    // table memory: {valid, rank, source, destination, service}
    logic [WW-1:0] mem [TABLE_DEPTH];
    logic [WW-1:0] mem_rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [WW-1:0] mem_wdata;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic [lidt_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [IDW-1:0]         src_reg, src_next;
    logic [IDW-1:0]         dst_reg, dst_next;
    logic [IDW-1:0]         svc_reg, svc_next;
    logic                   pend_reg, pend_next;
    logic                   pend_upd_reg, pend_upd_next;
    logic [IW-1:0]          pend_idx_reg, pend_idx_next;
    logic                   exact_hit_reg, exact_hit_next;
    logic [IW-1:0]          exact_idx_reg, exact_idx_next;
    logic [SW-1:0]          exact_rank_reg, exact_rank_next;
    logic                   free_found_reg, free_found_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic                   dv_hit_reg, dv_hit_next;
    logic [SW-1:0]          best_rank_reg, best_rank_next;
    logic [IDW-1:0]         best_src_reg, best_src_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   upd_insert_reg, upd_insert_next;
    logic                   done_reg, done_next;
    logic                   hit_reg, hit_next;
    logic [IDW-1:0]         found_reg, found_next;
    logic                   dropped_reg, dropped_next;
    logic [lidt_pkg::TOTAL_W-1:0] total_reg, total_next;

    // fields of the word read last cycle
    logic           r_valid;
    logic [SW-1:0]  r_rank;
    logic [IDW-1:0] r_src;
    logic [IDW-1:0] r_dst;
    logic [IDW-1:0] r_svc;
    logic           r_dv_match;
    logic           r_exact;

    assign r_valid    = mem_rdata_reg[WW-1];
    assign r_rank     = mem_rdata_reg[WW-2 -: SW];
    assign r_src      = mem_rdata_reg[3*IDW-1 -: IDW];
    assign r_dst      = mem_rdata_reg[2*IDW-1 -: IDW];
    assign r_svc      = mem_rdata_reg[IDW-1:0];
    assign r_dv_match = r_valid && (r_dst == dst_reg) && (r_svc == svc_reg);
    assign r_exact    = r_dv_match && (r_src == src_reg);

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // sequencer, scan accumulators and re-rank write-back
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        svc_next        = svc_reg;
        pend_next       = 1'b0;
        pend_upd_next   = pend_upd_reg;
        pend_idx_next   = pend_idx_reg;
        exact_hit_next  = exact_hit_reg;
        exact_idx_next  = exact_idx_reg;
        exact_rank_next = exact_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dv_hit_next     = dv_hit_reg;
        best_rank_next  = best_rank_reg;
        best_src_next   = best_src_reg;
        count_next      = count_reg;
        upd_insert_next = upd_insert_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        found_next      = found_reg;
        dropped_next    = dropped_reg;
        total_next      = total_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = pend_idx_reg;
        mem_raddr       = cnt_reg;
        mem_wdata       = mem_rdata_reg;

        // data of the entry read last cycle
        if (pend_reg)
        begin
            if (pend_upd_reg)
            begin
                mem_we = 1'b1;
                if (upd_insert_reg)
                begin
                    if (pend_idx_reg == free_idx_reg)
                    begin
                        mem_wdata = {1'b1, {SW{1'b0}}, src_reg, dst_reg, svc_reg};
                    end
                    else if (r_valid)
                    begin
                        mem_wdata = {1'b1, r_rank + SW'(1), r_src, r_dst, r_svc};
                    end
                end
                else
                begin
                    if (pend_idx_reg == exact_idx_reg)
                    begin
                        mem_wdata = {1'b0, r_rank, r_src, r_dst, r_svc};
                    end
                    else if (r_valid && (r_rank > exact_rank_reg))
                    begin
                        mem_wdata = {1'b1, r_rank - SW'(1), r_src, r_dst, r_svc};
                    end
                end
            end
            else
            begin
                // exact key match
                if (r_exact && !exact_hit_reg)
                begin
                    exact_hit_next  = 1'b1;
                    exact_idx_next  = pend_idx_reg;
                    exact_rank_next = r_rank;
                end
                // lowest free slot
                if (!r_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = pend_idx_reg;
                end
                // newest destination and service match
                if (r_dv_match && (!dv_hit_reg || (r_rank < best_rank_reg)))
                begin
                    best_rank_next = r_rank;
                    best_src_next  = r_src;
                end
                if (r_dv_match)
                begin
                    dv_hit_next = 1'b1;
                end
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    src_next        = source_id;
                    dst_next        = dest_id;
                    svc_next        = service_kind;
                    exact_hit_next  = 1'b0;
                    free_found_next = 1'b0;
                    dv_hit_next     = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_re        = 1'b1;
                pend_next     = 1'b1;
                pend_upd_next = 1'b0;
                pend_idx_next = cnt_reg;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_SCAN_END;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                done_next    = 1'b1;
                hit_next     = 1'b0;
                found_next   = '0;
                dropped_next = 1'b0;
                cnt_next     = '0;
                state_next   = ST_IDLE;
                case (cmd_reg)
                    lidt_pkg::CMD_INSERT:
                    begin
                        if (exact_hit_reg)
                        begin
                            hit_next = 1'b1;
                        end
                        else if (!free_found_reg)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            count_next      = count_reg + CW'(1);
                            upd_insert_next = 1'b1;
                            state_next      = ST_UPDATE;
                        end
                    end
                    lidt_pkg::CMD_DELETE:
                    begin
                        if (exact_hit_reg)
                        begin
                            hit_next        = 1'b1;
                            count_next      = count_reg - CW'(1);
                            upd_insert_next = 1'b0;
                            state_next      = ST_UPDATE;
                        end
                    end
                    lidt_pkg::CMD_FIND:
                    begin
                        hit_next = exact_hit_reg;
                    end
                    lidt_pkg::CMD_FIND_SRC:
                    begin
                        hit_next   = dv_hit_reg;
                        found_next = dv_hit_reg ? best_src_reg : lidt_pkg::MISS_SOURCE;
                    end
                    default:
                    begin
                        hit_next = 1'b0;
                    end
                endcase
                total_next = lidt_pkg::TOTAL_W'(count_next);
            end
            ST_UPDATE:
            begin
                mem_re        = 1'b1;
                pend_next     = 1'b1;
                pend_upd_next = 1'b1;
                pend_idx_next = cnt_reg;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE_END;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            ST_UPDATE_END:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            cmd_reg        <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            svc_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_upd_reg   <= 1'b0;
            pend_idx_reg   <= '0;
            exact_hit_reg  <= 1'b0;
            exact_idx_reg  <= '0;
            exact_rank_reg <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            dv_hit_reg     <= 1'b0;
            best_rank_reg  <= '0;
            best_src_reg   <= '0;
            count_reg      <= '0;
            upd_insert_reg <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            found_reg      <= '0;
            dropped_reg    <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cmd_reg        <= cmd_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            svc_reg        <= svc_next;
            pend_reg       <= pend_next;
            pend_upd_reg   <= pend_upd_next;
            pend_idx_reg   <= pend_idx_next;
            exact_hit_reg  <= exact_hit_next;
            exact_idx_reg  <= exact_idx_next;
            exact_rank_reg <= exact_rank_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            dv_hit_reg     <= dv_hit_next;
            best_rank_reg  <= best_rank_next;
            best_src_reg   <= best_src_next;
            count_reg      <= count_next;
            upd_insert_reg <= upd_insert_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            found_reg      <= found_next;
            dropped_reg    <= dropped_next;
            total_reg      <= total_next;
        end
    end

    // outputs
    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign found_source = found_reg;
    assign dropped      = dropped_reg;
    assign entry_total  = total_reg;

endmodule
